// ===== src/irlin_pkg.sv =====
`default_nettype none

package irlin_pkg;

  // block averaging
  localparam int unsigned BLOCK_SAMPLES = 20;
  localparam int unsigned SAMPLE_W      = 10;
  localparam int unsigned AVG_W         = SAMPLE_W;
  localparam int unsigned DIST_W        = 7;
  localparam int unsigned SUM_W         = $clog2(BLOCK_SAMPLES * (2 ** SAMPLE_W - 1) + 1);
  localparam int unsigned CNT_W         = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;

  // floor(sum / BLOCK_SAMPLES) as multiply by rounded-up reciprocal and shift
  localparam int unsigned SUM_SHIFT   = SUM_W + $clog2(BLOCK_SAMPLES) + 1;
  localparam int unsigned SUM_RECIP_W = SUM_SHIFT - $clog2(BLOCK_SAMPLES) + 1;
  localparam logic [SUM_RECIP_W-1:0] SUM_RECIP =
    SUM_RECIP_W'(((2 ** SUM_SHIFT) + BLOCK_SAMPLES - 1) / BLOCK_SAMPLES);
  localparam int unsigned SUM_PROD_W  = SUM_W + SUM_RECIP_W;

  // breakpoint table, segment divisors in hundredths
  localparam int unsigned SEGMENTS = 7;
  localparam int unsigned SEG_W    = 3;
  localparam logic [AVG_W-1:0] BP_CODE [SEGMENTS] = '{
    AVG_W'(80), AVG_W'(87), AVG_W'(106), AVG_W'(124), AVG_W'(150), AVG_W'(196), AVG_W'(276)
  };
  localparam logic [DIST_W-1:0] BP_DIST [SEGMENTS] = '{
    DIST_W'(80), DIST_W'(70), DIST_W'(60), DIST_W'(50), DIST_W'(40), DIST_W'(30), DIST_W'(20)
  };
  localparam int unsigned BP_DIV [SEGMENTS] = '{77, 211, 200, 288, 511, 888, 2377};

  localparam logic [AVG_W-1:0]  NEAR_CODE = AVG_W'(80);
  localparam logic [DIST_W-1:0] NEAR_DIST = DIST_W'(80);
  localparam logic [AVG_W-1:0]  TOP_CODE  = AVG_W'(490);
  localparam logic [DIST_W-1:0] TOP_DIST  = DIST_W'(10);

  // ceil(x * 100 / D) as floor((x * 100 + D - 1) * recip >> shift)
  localparam int unsigned DROP_SCALE  = 100;
  localparam int unsigned NUM_W       = 15;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;
  localparam int unsigned DROP_W      = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] DIV_RECIP [SEGMENTS] = '{
    RECIP_W'(((2 ** RECIP_SHIFT) + 77 - 1) / 77),
    RECIP_W'(((2 ** RECIP_SHIFT) + 211 - 1) / 211),
    RECIP_W'(((2 ** RECIP_SHIFT) + 200 - 1) / 200),
    RECIP_W'(((2 ** RECIP_SHIFT) + 288 - 1) / 288),
    RECIP_W'(((2 ** RECIP_SHIFT) + 511 - 1) / 511),
    RECIP_W'(((2 ** RECIP_SHIFT) + 888 - 1) / 888),
    RECIP_W'(((2 ** RECIP_SHIFT) + 2377 - 1) / 2377)
  };

  // stream widths
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 24;

endpackage

`default_nettype wire

// ===== src/ir_range_average_linearize_unit.sv =====
// IR range sensor averaging and linearization
//
// Input stream (s_axis_*): one raw converter sample per request, accepted when
// tvalid and tready are both high. A new sample can be taken every cycle.
// Samples are summed in blocks of irlin_pkg::BLOCK_SAMPLES. The last sample of
// a block closes it and starts one result; all other samples give no result.
// Output stream (m_axis_*): one request per block, carrying the distance in
// whole centimeters and the floor average of the block.
// Path: once the block's last sample is accepted, its sum is registered, then
// the average, then the segment select and numerator, and a reciprocal
// multiply feeds the output register that presents the result.
// Throughput: one sample per cycle, set by the accumulator register.
// Reset clears the running sum, the sample count, the held distance (which
// reads 0 until the first result) and all stage valid bits.
// When the receiver stalls, the result waits in the output register and the
// stages behind it fill up; samples that do not close a block are still taken,
// and a closing sample is held off only while the first stage cannot move.
`default_nettype none

module ir_range_average_linearize_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output      logic                            s_axis_tready_o,
  // [9:0] sample, upper bits padding
  input  wire logic [irlin_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output      logic                            m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [6:0] distance_cm, [16:7] average_code, upper bits zero
  output      logic [irlin_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  typedef enum logic [1:0] {
    CLS_LINEAR,
    CLS_NEAR,
    CLS_TOP,
    CLS_HOLD
  } cls_e;

  // accumulator
  logic [irlin_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [irlin_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [irlin_pkg::SUM_W-1:0]    total;
  logic [irlin_pkg::SAMPLE_W-1:0] sample;
  logic                           blk_last;
  logic                           in_acc;

  // stage 1: block sum
  logic                           v1_q;
  logic [irlin_pkg::SUM_W-1:0]    sum1_q;
  // stage 2: average
  logic                           v2_q;
  logic [irlin_pkg::AVG_W-1:0]    avg2_q;
  // stage 3: segment and numerator
  logic                           v3_q;
  logic [irlin_pkg::AVG_W-1:0]    avg3_q;
  cls_e                           cls3_q;
  logic [irlin_pkg::SEG_W-1:0]    seg3_q;
  logic [irlin_pkg::NUM_W-1:0]    num3_q;
  // output register
  logic                           vo_q;
  logic [irlin_pkg::DIST_W-1:0]   dist_q;
  logic [irlin_pkg::AVG_W-1:0]    avgo_q;
  logic [irlin_pkg::DIST_W-1:0]   held_q;

  logic rdy1, rdy2, rdy3, rdyo;

  // stage moves when it is empty or the next one moves
  assign rdyo = !vo_q || m_axis_tready_i;
  assign rdy3 = !v3_q || rdyo;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  // input side
  assign sample          = s_axis_tdata_i[irlin_pkg::SAMPLE_W-1:0];
  assign blk_last        = (cnt_q == irlin_pkg::CNT_W'(irlin_pkg::BLOCK_SAMPLES - 1));
  assign s_axis_tready_o = !blk_last || rdy1;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign total           = sum_q + irlin_pkg::SUM_W'(sample);

  // running sum and count
  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      if (blk_last) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = total;
        cnt_d = cnt_q + irlin_pkg::CNT_W'(1);
      end
    end
  end

  // average by reciprocal multiply
  logic [irlin_pkg::SUM_PROD_W-1:0] avg_prod;
  logic [irlin_pkg::AVG_W-1:0]      avg_d;

  assign avg_prod = irlin_pkg::SUM_PROD_W'(sum1_q)
                  * irlin_pkg::SUM_PROD_W'(irlin_pkg::SUM_RECIP);
  assign avg_d    = avg_prod[irlin_pkg::SUM_SHIFT +: irlin_pkg::AVG_W];

  // segment select, class and rounded-up numerator
  logic [irlin_pkg::SEG_W-1:0] seg_d;
  cls_e                        cls_d;
  logic [irlin_pkg::AVG_W-1:0] seg_x;
  logic [irlin_pkg::NUM_W-1:0] num_d;

  always_comb begin
    seg_d = '0;
    for (int s = 1; s < irlin_pkg::SEGMENTS; s++) begin
      if (avg2_q >= irlin_pkg::BP_CODE[s]) begin
        seg_d = irlin_pkg::SEG_W'(s);
      end
    end
    if (avg2_q <= irlin_pkg::NEAR_CODE) begin
      cls_d = CLS_NEAR;
    end else if (avg2_q == irlin_pkg::TOP_CODE) begin
      cls_d = CLS_TOP;
    end else if (avg2_q > irlin_pkg::TOP_CODE) begin
      cls_d = CLS_HOLD;
    end else begin
      cls_d = CLS_LINEAR;
    end
    seg_x = avg2_q - irlin_pkg::BP_CODE[seg_d];
    num_d = irlin_pkg::NUM_W'(seg_x) * irlin_pkg::NUM_W'(irlin_pkg::DROP_SCALE)
          + irlin_pkg::NUM_W'(irlin_pkg::BP_DIV[seg_d] - 1);
  end

  // drop in centimeters and final distance
  logic [irlin_pkg::PROD_W-1:0] drop_prod;
  logic [irlin_pkg::DROP_W-1:0] drop;
  logic [irlin_pkg::DIST_W-1:0] base;
  logic [irlin_pkg::DIST_W-1:0] lin_dist;
  logic [irlin_pkg::DIST_W-1:0] dist_d;

  assign drop_prod = irlin_pkg::PROD_W'(num3_q)
                   * irlin_pkg::PROD_W'(irlin_pkg::DIV_RECIP[seg3_q]);
  assign drop      = drop_prod[irlin_pkg::PROD_W-1:irlin_pkg::RECIP_SHIFT];
  assign base      = irlin_pkg::BP_DIST[seg3_q];

  always_comb begin
    if (drop >= irlin_pkg::DROP_W'(base)) begin
      lin_dist = '0;
    end else begin
      lin_dist = base - irlin_pkg::DIST_W'(drop);
    end
    case (cls3_q)
      CLS_NEAR: dist_d = irlin_pkg::NEAR_DIST;
      CLS_TOP:  dist_d = irlin_pkg::TOP_DIST;
      CLS_HOLD: dist_d = held_q;
      default:  dist_d = lin_dist;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vo_q   <= 1'b0;
      held_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      if (rdy1) begin
        v1_q <= in_acc && blk_last;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdyo) begin
        vo_q <= v3_q;
      end
      if (rdyo && v3_q) begin
        held_q <= dist_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_acc && blk_last) begin
      sum1_q <= total;
    end
    if (rdy2 && v1_q) begin
      avg2_q <= avg_d;
    end
    if (rdy3 && v2_q) begin
      avg3_q <= avg2_q;
      cls3_q <= cls_d;
      seg3_q <= seg_d;
      num3_q <= num_d;
    end
    if (rdyo && v3_q) begin
      dist_q <= dist_d;
      avgo_q <= avg3_q;
    end
  end

  // output stream
  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = irlin_pkg::M_TDATA_W'({avgo_q, dist_q});

  // a closing sample always starts a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && blk_last) |=> v1_q)
    else $error("closing sample did not enter the sum stage");

  // the held distance always matches the result on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> (held_q == dist_q))
    else $error("held distance differs from output distance");

  // distance never exceeds the near distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> (dist_q <= irlin_pkg::NEAR_DIST))
    else $error("distance out of range");

  // count stays inside one block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= irlin_pkg::CNT_W'(irlin_pkg::BLOCK_SAMPLES - 1))
    else $error("sample count beyond block length");

endmodule

`default_nettype wire

// ===== tb/tb_ir_range_average_linearize_unit.sv =====
`timescale 1ns / 100ps

module tb_ir_range_average_linearize_unit;

  // block size and breakpoint table, kept apart from the design's own copy
  localparam int unsigned BLOCK_LEN   = 20;
  localparam int unsigned SEG_COUNT   = 7;
  localparam int unsigned NEAR_LIMIT  = 80;
  localparam int unsigned NEAR_RANGE  = 80;
  localparam int unsigned FAR_CODE    = 490;
  localparam int unsigned FAR_RANGE   = 10;
  localparam int unsigned SAMPLE_MAX  = 1023;
  localparam int unsigned RUN_SAMPLES = 1600;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned SHOW_LIMIT  = 10;

  localparam int unsigned SEG_CODE [SEG_COUNT] = '{80, 87, 106, 124, 150, 196, 276};
  localparam int unsigned SEG_RANGE [SEG_COUNT] = '{80, 70, 60, 50, 40, 30, 20};
  localparam int unsigned SEG_DIV [SEG_COUNT] = '{77, 211, 200, 288, 511, 888, 2377};

  // packed from the top bit down: average_code in [16:7], distance_cm in [6:0]
  typedef struct packed {
    logic [9:0] average_code;
    logic [6:0] distance_cm;
  } range_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [irlin_pkg::S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [irlin_pkg::M_TDATA_W-1:0] m_axis_tdata_o;

  // predictor state
  int unsigned   block_sum;
  int unsigned   block_count;
  logic [6:0]    last_distance;
  range_result_t pending_ranges [$];

  // run control
  bit          no_idle;
  bit          drive_padding;
  int unsigned samples_sent;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned result_stall;
  range_result_t got_range;
  range_result_t want_range;

  ir_range_average_linearize_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // map a block average to centimeters through the breakpoint segments
  function automatic logic [6:0] range_from_average(input int unsigned avg,
                                                    input logic [6:0] held);
    int          seg;
    int unsigned x;
    int unsigned drop;
    if (avg <= NEAR_LIMIT) return 7'(NEAR_RANGE);
    if (avg == FAR_CODE) return 7'(FAR_RANGE);
    if (avg > FAR_CODE) return held;
    seg = SEG_COUNT - 1;
    while (seg > 0 && avg < SEG_CODE[seg]) seg--;
    x    = avg - SEG_CODE[seg];
    drop = (x * 100 + SEG_DIV[seg] - 1) / SEG_DIV[seg];
    return (drop >= SEG_RANGE[seg]) ? 7'd0 : 7'(SEG_RANGE[seg] - drop);
  endfunction

  // add one accepted sample, close the block on the last one
  task automatic accumulate_sample(input logic [9:0] sample);
    range_result_t r;
    int unsigned   avg;
    block_sum   += sample;
    block_count += 1;
    if (block_count == BLOCK_LEN) begin
      avg           = block_sum / BLOCK_LEN;
      block_sum     = 0;
      block_count   = 0;
      last_distance = range_from_average(avg, last_distance);
      r.distance_cm  = last_distance;
      r.average_code = avg[9:0];
      pending_ranges.push_back(r);
    end
  endtask

  function automatic int unsigned clamp_sample(input int v);
    if (v < 0) return 0;
    if (v > int'(SAMPLE_MAX)) return SAMPLE_MAX;
    return v;
  endfunction

  // one sample request with a random lead-in gap
  task automatic send_sample(input logic [9:0] sample);
    int unsigned gap;
    logic [irlin_pkg::S_TDATA_W-1:0] word;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    word       = drive_padding ? irlin_pkg::S_TDATA_W'($urandom) : '0;
    word[9:0]  = sample;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    accumulate_sample(sample);
    samples_sent++;
  endtask

  // one block of samples spread around a target average
  task automatic send_block(input int target, input int spread);
    for (int i = 0; i < BLOCK_LEN; i++) begin
      send_sample(10'(clamp_sample(target + $urandom_range(0, 2 * spread) - spread)));
    end
  endtask

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    if (mismatches < SHOW_LIMIT) begin
      $display("mismatch %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
    end
    mismatches++;
  endtask

  // result side: check each request, then draw the stall before the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_range = range_result_t'(m_axis_tdata_o[16:0]);
        if (pending_ranges.size() == 0) begin
          note_mismatch("unexpected result, average", 0, got_range.average_code);
        end else begin
          want_range = pending_ranges.pop_front();
          if (got_range.distance_cm !== want_range.distance_cm)
            note_mismatch("distance_cm", want_range.distance_cm, got_range.distance_cm);
          if (got_range.average_code !== want_range.average_code)
            note_mismatch("average_code", want_range.average_code, got_range.average_code);
        end
        result_stall <= no_idle ? 0 : $urandom_range(0, 7);
      end
      // watchdog on cycles with no request moving on either side
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_ir_range_average_linearize_unit: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver ready, held low for the drawn stall
  always @(negedge clk_i) begin
    if (result_stall > 0) begin
      m_axis_tready_i <= 1'b0;
      result_stall    <= result_stall - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // far blocks before any distance repeat the cleared held value
  task automatic test_held_after_reset();
    send_block(SAMPLE_MAX, 0);
    send_block(700, 0);
  endtask

  // exact breakpoints, the near limit, the top code and above it
  task automatic test_breakpoints();
    int unsigned codes [11] = '{0, 80, 87, 106, 124, 150, 196, 276, 490, 491, 1023};
    foreach (codes[i]) send_block(codes[i], 0);
  endtask

  // one code on each side of every breakpoint above 80, plus 81 and 489
  task automatic test_segment_interiors();
    int unsigned codes [14] = '{81, 86, 88, 105, 107, 123, 125, 149, 151, 195, 197, 275,
                                277, 489};
    foreach (codes[i]) send_block(codes[i], 0);
  endtask

  // fractional averages must round down
  task automatic test_floor_average();
    for (int i = 0; i < BLOCK_LEN - 1; i++) send_sample(10'd100);
    send_sample(10'd119);
    for (int i = 0; i < BLOCK_LEN - 1; i++) send_sample(10'd80);
    send_sample(10'd99);
  endtask

  // padding bits above the sample carry no weight
  task automatic test_padding_ignored();
    drive_padding = 1'b1;
    send_block(150, 20);
    send_block(300, 0);
    drive_padding = 1'b0;
  endtask

  // random blocks: mostly targeted averages, some near breakpoints, some noise
  task automatic test_random_blocks(input int unsigned last_sample);
    int unsigned pick;
    while (samples_sent < last_sample) begin
      pick          = $urandom_range(0, 9);
      drive_padding = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 5) == 0) no_idle = ~no_idle;
      if (pick == 0) begin
        for (int i = 0; i < BLOCK_LEN; i++) send_sample(10'($urandom));
      end else if (pick == 1) begin
        send_block(SEG_CODE[$urandom_range(0, SEG_COUNT - 1)] + $urandom_range(0, 4) - 2, 0);
      end else if (pick == 2) begin
        send_block(FAR_CODE + $urandom_range(0, 4) - 2, $urandom_range(0, 3));
      end else begin
        send_block($urandom_range(60, 560), $urandom_range(0, 40));
      end
    end
    no_idle       = 1'b0;
    drive_padding = 1'b0;
  endtask

  // full rate on both sides
  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int b = 0; b < 10; b++) send_block($urandom_range(0, SAMPLE_MAX), $urandom_range(0, 60));
    no_idle = 1'b0;
  endtask

  initial begin
    block_sum     = 0;
    block_count   = 0;
    last_distance = '0;
    no_idle       = 1'b0;
    drive_padding = 1'b0;
    samples_sent  = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    result_stall  = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_held_after_reset();
    test_breakpoints();
    test_segment_interiors();
    test_floor_average();
    test_padding_ignored();
    test_back_to_back();
    test_random_blocks(RUN_SAMPLES);

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_ir_range_average_linearize_unit: PASS");
    end else begin
      $display("tb_ir_range_average_linearize_unit: FAIL");
    end
    $finish;
  end

endmodule

// ===== ir_range_average_linearize_unit.f =====
src/irlin_pkg.sv
src/ir_range_average_linearize_unit.sv
tb/tb_ir_range_average_linearize_unit.sv
